// ===== rtl/core/fap_pkg.sv =====
// Package for the fixed-point ALU: constants, operation codes and word types.
package fap_pkg;

   localparam int FRAC_BITS = 8;
   localparam int DATA_W    = 32;
   localparam int QUO_W     = DATA_W + FRAC_BITS;
   localparam int PROD_W    = 2 * DATA_W;
   localparam int LATENCY   = QUO_W + 2;

   typedef enum logic [3:0] {
      KIND_ADD  = 4'd0,
      KIND_SUB  = 4'd1,
      KIND_MUL  = 4'd2,
      KIND_DIV  = 4'd3,
      KIND_MIN  = 4'd4,
      KIND_MAX  = 4'd5,
      KIND_INC  = 4'd6,
      KIND_DEC  = 4'd7,
      KIND_FROM = 4'd8,
      KIND_TO   = 4'd9,
      KIND_CMP  = 4'd10
   } kind_type;

   typedef struct packed {
      logic [3:0]               kind;
      logic signed [DATA_W-1:0] operand_a;
      logic signed [DATA_W-1:0] operand_b;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] result;
      logic                     is_less;
      logic                     is_equal;
      logic                     is_greater;
      logic                     overflow;
      logic                     div_by_zero;
   } rsp_type;

   typedef struct packed {
      logic              valid;
      logic [3:0]        kind;
      logic [DATA_W-1:0] simple;
      logic              simple_ovf;
      logic              is_less;
      logic              is_equal;
      logic              is_greater;
      logic              neg;
      logic              dz;
      logic [PROD_W-1:0] prod;
      logic [DATA_W-1:0] dvs;
      logic [DATA_W-1:0] rem;
      logic [QUO_W-1:0]  dvd;
      logic [QUO_W-1:0]  quo;
   } cell_type;

endpackage

// ===== rtl/core/fap_front.sv =====
// Input stage: operand magnitudes, product, simple operations and flags.
module fap_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             take,
   input  fap_pkg::req_type req_word,
   output fap_pkg::cell_type cell_out
);

   fap_pkg::cell_type cell_ff, cell_in;
   logic signed [fap_pkg::DATA_W:0]   sum_w;
   logic signed [fap_pkg::PROD_W-1:0] wide_w;
   logic [fap_pkg::DATA_W-1:0]        amag, bmag;
   logic                              a_gt_b;

   always_comb begin
      amag = req_word.operand_a[fap_pkg::DATA_W-1] ? (~req_word.operand_a + 1'b1)
                                                   : req_word.operand_a;
      bmag = req_word.operand_b[fap_pkg::DATA_W-1] ? (~req_word.operand_b + 1'b1)
                                                   : req_word.operand_b;
      a_gt_b = req_word.operand_a > req_word.operand_b;
      wide_w = fap_pkg::PROD_W'(req_word.operand_a) <<< fap_pkg::FRAC_BITS;
      sum_w  = '0;
      cell_in = '0;
      cell_in.valid      = take;
      cell_in.kind       = req_word.kind;
      cell_in.is_less    = req_word.operand_a < req_word.operand_b;
      cell_in.is_equal   = req_word.operand_a == req_word.operand_b;
      cell_in.is_greater = a_gt_b;
      cell_in.neg  = req_word.operand_a[fap_pkg::DATA_W-1] ^ req_word.operand_b[fap_pkg::DATA_W-1];
      cell_in.dz   = req_word.operand_b == '0;
      cell_in.prod = amag * bmag;
      cell_in.dvs  = bmag;
      cell_in.rem  = '0;
      cell_in.dvd  = fap_pkg::QUO_W'(amag) << fap_pkg::FRAC_BITS;
      cell_in.quo  = '0;
      case (fap_pkg::kind_type'(req_word.kind))
         fap_pkg::KIND_ADD: sum_w = (fap_pkg::DATA_W+1)'(req_word.operand_a)
                                    + (fap_pkg::DATA_W+1)'(req_word.operand_b);
         fap_pkg::KIND_SUB: sum_w = (fap_pkg::DATA_W+1)'(req_word.operand_a)
                                    - (fap_pkg::DATA_W+1)'(req_word.operand_b);
         fap_pkg::KIND_INC: sum_w = (fap_pkg::DATA_W+1)'(req_word.operand_a)
                                    + (fap_pkg::DATA_W+1)'(1);
         fap_pkg::KIND_DEC: sum_w = (fap_pkg::DATA_W+1)'(req_word.operand_a)
                                    - (fap_pkg::DATA_W+1)'(1);
         default:           sum_w = '0;
      endcase
      case (fap_pkg::kind_type'(req_word.kind))
         fap_pkg::KIND_ADD, fap_pkg::KIND_SUB, fap_pkg::KIND_INC, fap_pkg::KIND_DEC: begin
            cell_in.simple     = sum_w[fap_pkg::DATA_W-1:0];
            cell_in.simple_ovf = sum_w[fap_pkg::DATA_W] != sum_w[fap_pkg::DATA_W-1];
         end
         fap_pkg::KIND_MIN: cell_in.simple = a_gt_b ? req_word.operand_b : req_word.operand_a;
         fap_pkg::KIND_MAX: cell_in.simple = a_gt_b ? req_word.operand_a : req_word.operand_b;
         fap_pkg::KIND_FROM: begin
            cell_in.simple     = wide_w[fap_pkg::DATA_W-1:0];
            cell_in.simple_ovf = (wide_w[fap_pkg::PROD_W-1:fap_pkg::DATA_W-1] != '0)
                              && (wide_w[fap_pkg::PROD_W-1:fap_pkg::DATA_W-1] != '1);
         end
         fap_pkg::KIND_TO: cell_in.simple = req_word.operand_a >>> fap_pkg::FRAC_BITS;
         default: begin
            cell_in.simple     = '0;
            cell_in.simple_ovf = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff <= '0;
      end else begin
         cell_ff <= cell_in;
      end
   end

   assign cell_out = cell_ff;

endmodule

// ===== rtl/core/fap_div_cell.sv =====
// Divider cell: one restoring quotient step, passes the word to its neighbor.
module fap_div_cell (
   input  logic              clock,
   input  logic              reset,
   input  fap_pkg::cell_type cell_in_word,
   output fap_pkg::cell_type cell_out_word
);

   fap_pkg::cell_type cell_ff, cell_in;
   logic [fap_pkg::DATA_W+1:0] diff;
   logic                       ge;

   always_comb begin
      diff = {1'b0, cell_in_word.rem, cell_in_word.dvd[fap_pkg::QUO_W-1]}
             - {2'b00, cell_in_word.dvs};
      ge   = !diff[fap_pkg::DATA_W+1];
      cell_in     = cell_in_word;
      cell_in.rem = ge ? diff[fap_pkg::DATA_W-1:0]
                       : {cell_in_word.rem[fap_pkg::DATA_W-2:0],
                          cell_in_word.dvd[fap_pkg::QUO_W-1]};
      cell_in.dvd = cell_in_word.dvd << 1;
      cell_in.quo = {cell_in_word.quo[fap_pkg::QUO_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff <= '0;
      end else begin
         cell_ff <= cell_in;
      end
   end

   assign cell_out_word = cell_ff;

endmodule

// ===== rtl/core/fap_back.sv =====
// Output stage: sign and range of product and quotient, result select.
module fap_back (
   input  logic              clock,
   input  logic              reset,
   input  fap_pkg::cell_type cell_word,
   output logic              rsp_strobe,
   output fap_pkg::rsp_type  rsp_word
);

   fap_pkg::rsp_type          rsp_ff, rsp_in;
   logic                      valid_ff;
   logic [fap_pkg::PROD_W-1:0] mag, sres;
   logic                       big;
   localparam logic [fap_pkg::PROD_W-1:0] LIM = fap_pkg::PROD_W'(1) << (fap_pkg::DATA_W-1);

   always_comb begin
      if (fap_pkg::kind_type'(cell_word.kind) == fap_pkg::KIND_MUL) begin
         mag = cell_word.prod >> fap_pkg::FRAC_BITS;
      end else begin
         mag = fap_pkg::PROD_W'(cell_word.quo);
      end
      sres = cell_word.neg ? (~mag + 1'b1) : mag;
      big  = cell_word.neg ? (mag > LIM) : (mag >= LIM);
      rsp_in = '0;
      rsp_in.is_less    = cell_word.is_less;
      rsp_in.is_equal   = cell_word.is_equal;
      rsp_in.is_greater = cell_word.is_greater;
      case (fap_pkg::kind_type'(cell_word.kind))
         fap_pkg::KIND_MUL: begin
            rsp_in.result   = sres[fap_pkg::DATA_W-1:0];
            rsp_in.overflow = big;
         end
         fap_pkg::KIND_DIV: begin
            rsp_in.div_by_zero = cell_word.dz;
            rsp_in.result      = cell_word.dz ? '0 : sres[fap_pkg::DATA_W-1:0];
            rsp_in.overflow    = !cell_word.dz && big;
         end
         default: begin
            rsp_in.result   = cell_word.simple;
            rsp_in.overflow = cell_word.simple_ovf;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= cell_word.valid;
      end
   end

   assign rsp_strobe = valid_ff;
   assign rsp_word   = rsp_ff;

endmodule

// ===== rtl/core/fixed_point_alu_top.sv =====
// Top level of the signed fixed-point ALU with a pipelined divider chain.
//   channel  ports                        direction
//   request  start, busy, req_word        in
//   response rsp_strobe, rsp_word         out
// One word is taken every cycle; busy stays low.
// Every word passes the front register, one divider cell per quotient bit
// (QUO_W = 32 + FRAC_BITS cells) and then the back register.
// Synchronous reset empties the pipeline; the receiver cannot stall.
module fixed_point_alu_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  fap_pkg::req_type req_word,
   output logic             rsp_strobe,
   output fap_pkg::rsp_type rsp_word
);

   fap_pkg::cell_type chain [0:fap_pkg::QUO_W];

   assign busy = 1'b0;

   fap_front u_front (
      .clock    (clock),
      .reset    (reset),
      .take     (start && !busy),
      .req_word (req_word),
      .cell_out (chain[0])
   );

   for (genvar i = 0; i < fap_pkg::QUO_W; i++) begin : g_cell
      fap_div_cell u_cell (
         .clock         (clock),
         .reset         (reset),
         .cell_in_word  (chain[i]),
         .cell_out_word (chain[i+1])
      );
   end

   fap_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cell_word  (chain[fap_pkg::QUO_W]),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

`ifndef SYNTH
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(fap_pkg::LATENCY) rsp_strobe)
      else $error("response missing after fixed latency");
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_word.div_by_zero) |-> (rsp_word.result == '0 && !rsp_word.overflow))
      else $error("divide by zero gave nonzero result");
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $onehot({rsp_word.is_less, rsp_word.is_equal, rsp_word.is_greater}))
      else $error("compare flags not one-hot");
`endif

endmodule
